// ===== src/mpfb_pkg.sv =====
// shared types and constants of the page-packed frame buffer drawing engine
`default_nettype none

package mpfb_pkg;

    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 64;
    localparam int STORE_BYTES = 1024;

    localparam int DATA_W    = 8;
    localparam int ADDR_W    = $clog2(STORE_BYTES);
    localparam int WALK_W    = ADDR_W + 1;
    localparam int PAGE_W    = $clog2(MAX_HEIGHT / 8);
    localparam int WIDTH_W   = 8;
    localparam int HEIGHT_W  = 7;
    localparam int COL_W     = 8;
    localparam int ROW_W     = 7;
    localparam int OP_W      = 3;
    localparam int CFG_IDX_W = 1;
    localparam int S_DATA_W  = 48;

    localparam logic [DATA_W-1:0] FULL_BYTE = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_FILL  = 3'd0,
        OP_PIXEL = 3'd1,
        OP_HLINE = 3'd2,
        OP_VLINE = 3'd3,
        OP_BOX   = 3'd4,
        OP_READ  = 3'd5,
        OP_RSV6  = 3'd6,
        OP_RSV7  = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_BUSY = 3'b010,
        S_HOLD = 3'b100
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  x_lo;
        logic [ADDR_W-1:0]  x_hi;
        logic [PAGE_W-1:0]  page_lo;
        logic [PAGE_W-1:0]  page_hi;
        logic [2:0]         y_lo;
        logic [2:0]         y_hi;
        logic [WIDTH_W-1:0] width;
        logic               color;
        logic               write_en;
    } walk_cmd_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] rdata;
    } walk_stat_t;

endpackage

`default_nettype wire

// ===== src/mpfb_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module mpfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/mpfb_walk.sv =====
// byte walker: steps over pages and columns, reads each byte and writes it back masked if enabled
`default_nettype none

module mpfb_walk (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire mpfb_pkg::walk_cmd_t  cmd,
    output mpfb_pkg::walk_stat_t      stat
);
    import mpfb_pkg::*;

    logic               active_reg;
    logic [ADDR_W-1:0]  x_reg;
    logic [ADDR_W-1:0]  x_lo_reg;
    logic [ADDR_W-1:0]  x_hi_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [PAGE_W-1:0]  page_lo_reg;
    logic [PAGE_W-1:0]  page_hi_reg;
    logic [2:0]         y_lo_reg;
    logic [2:0]         y_hi_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic               color_reg;
    logic               we_reg;
    logic [WALK_W-1:0]  base_reg;

    logic               wb_valid_reg;
    logic               wb_last_reg;
    logic               wb_we_reg;
    logic               wb_in_reg;
    logic [ADDR_W-1:0]  wb_addr_reg;
    logic [DATA_W-1:0]  wb_mask_reg;
    logic               wb_color_reg;

    logic [WALK_W-1:0]  cur_addr;
    logic [DATA_W-1:0]  mask;
    logic               x_last;
    logic               page_last;
    logic               active_next;
    logic [DATA_W-1:0]  ram_q;
    logic [DATA_W-1:0]  ram_wdata;
    logic               ram_we;

    always_comb
    begin
        cur_addr  = base_reg + WALK_W'(x_reg);
        x_last    = (x_reg == x_hi_reg);
        page_last = (page_reg == page_hi_reg);
        mask      = FULL_BYTE;
        if (page_reg == page_lo_reg)
        begin
            mask = mask & DATA_W'(FULL_BYTE << y_lo_reg);
        end
        if (page_last)
        begin
            mask = mask & DATA_W'(FULL_BYTE >> (3'd7 - y_hi_reg));
        end
    end

    always_comb
    begin
        active_next = active_reg;
        if (start)
        begin
            active_next = 1'b1;
        end
        else if (active_reg && x_last && page_last)
        begin
            active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg   <= active_next;
            wb_valid_reg <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg       <= cmd.x_lo;
            x_lo_reg    <= cmd.x_lo;
            x_hi_reg    <= cmd.x_hi;
            page_reg    <= cmd.page_lo;
            page_lo_reg <= cmd.page_lo;
            page_hi_reg <= cmd.page_hi;
            y_lo_reg    <= cmd.y_lo;
            y_hi_reg    <= cmd.y_hi;
            width_reg   <= cmd.width;
            color_reg   <= cmd.color;
            we_reg      <= cmd.write_en;
            base_reg    <= WALK_W'(WALK_W'(cmd.page_lo) * WALK_W'(cmd.width));
        end
        else if (active_reg)
        begin
            if (x_last)
            begin
                if (!page_last)
                begin
                    page_reg <= page_reg + PAGE_W'(1);
                    base_reg <= base_reg + WALK_W'(width_reg);
                    x_reg    <= x_lo_reg;
                end
            end
            else
            begin
                x_reg <= x_reg + ADDR_W'(1);
            end
        end
        wb_last_reg  <= x_last && page_last;
        wb_we_reg    <= we_reg;
        wb_in_reg    <= (cur_addr < WALK_W'(STORE_BYTES));
        wb_addr_reg  <= cur_addr[ADDR_W-1:0];
        wb_mask_reg  <= mask;
        wb_color_reg <= color_reg;
    end

    assign ram_we    = wb_valid_reg && wb_we_reg && wb_in_reg;
    assign ram_wdata = wb_color_reg ? (ram_q | wb_mask_reg) : (ram_q & ~wb_mask_reg);

    mpfb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wb_addr_reg),
        .wdata (ram_wdata),
        .raddr (cur_addr[ADDR_W-1:0]),
        .rdata (ram_q)
    );

    assign stat.busy  = active_reg || wb_valid_reg;
    assign stat.done  = wb_valid_reg && wb_last_reg;
    assign stat.rdata = wb_in_reg ? ram_q : '0;

endmodule

`default_nettype wire

// ===== src/mono_page_framebuffer_draw.sv =====
// top level of the page-packed monochrome frame buffer drawing engine
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  tdata: x_start y_start x_end y_end color read_addr
//                                   tuser: opcode
//  m_       out  m_tvalid/m_tready  tdata: read_data   tuser: dropped
//  cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one ram access per byte: a drawn shape walks pages * columns bytes,
// fill walks all STORE_BYTES bytes, a read one, a dropped or unused command none
// the next command is taken once the current result sits in the output register
// a stalled output holds the last result while one more command is worked on
// reset clears control and sets the geometry to full screen; buffer contents stay unknown
`default_nettype none

module mono_page_framebuffer_draw (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // x_start, y_start, x_end, y_end, color, read_addr, zero fill
    input  wire logic [mpfb_pkg::S_DATA_W-1:0]      s_tdata,
    // opcode
    input  wire logic [mpfb_pkg::OP_W-1:0]          s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // read_data
    output logic      [mpfb_pkg::DATA_W-1:0]        m_tdata,
    // dropped
    output logic      [0:0]                         m_tuser,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [mpfb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mpfb_pkg::WIDTH_W-1:0]       cfg_data
);
    import mpfb_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [WIDTH_W-1:0]  screen_width_reg;
    logic [HEIGHT_W-1:0] screen_height_reg;
    logic                m_tvalid_reg;
    logic [DATA_W-1:0]   m_tdata_reg;
    logic                m_tuser_reg;
    logic [DATA_W-1:0]   res_data_reg;
    logic                res_drop_reg;
    logic                is_read_reg;

    op_t                 op;
    logic [COL_W-1:0]    xs;
    logic [ROW_W-1:0]    ys;
    logic [COL_W-1:0]    xe;
    logic [ROW_W-1:0]    ye;
    logic                color;
    logic [ADDR_W-1:0]   read_addr;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [COL_W-1:0]    x_a;
    logic [COL_W-1:0]    x_b;
    logic [COL_W-1:0]    x_c;
    logic [ROW_W-1:0]    y_a;
    logic [ROW_W-1:0]    y_b;
    logic [ROW_W-1:0]    y_c;
    logic                is_draw;
    logic                drop;
    logic                accept;
    logic                start_walk;
    logic                out_free;
    walk_cmd_t           cmd;
    walk_stat_t          stat;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    assign op        = op_t'(s_tuser);
    assign xs        = s_tdata[7:0];
    assign ys        = s_tdata[14:8];
    assign color     = s_tdata[30];
    assign read_addr = s_tdata[40:31];

    always_comb
    begin
        w_eff = (screen_width_reg > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH)
                                                         : screen_width_reg;
        h_eff = (screen_height_reg > HEIGHT_W'(MAX_HEIGHT)) ? HEIGHT_W'(MAX_HEIGHT)
                                                            : screen_height_reg;
        xe      = s_tdata[22:15];
        ye      = s_tdata[29:23];
        is_draw = 1'b0;
        case (op)
            OP_PIXEL:
            begin
                xe      = xs;
                ye      = ys;
                is_draw = 1'b1;
            end
            OP_HLINE:
            begin
                ye      = ys;
                is_draw = 1'b1;
            end
            OP_VLINE:
            begin
                xe      = xs;
                is_draw = 1'b1;
            end
            OP_BOX:
            begin
                is_draw = 1'b1;
            end
            default:
            begin
                is_draw = 1'b0;
            end
        endcase
        x_a  = (xe < xs) ? xe : xs;
        x_b  = (xe < xs) ? xs : xe;
        y_a  = (ye < ys) ? ye : ys;
        y_b  = (ye < ys) ? ys : ye;
        drop = is_draw && ((x_a >= w_eff) || (y_a >= h_eff));
        x_c  = (x_b >= w_eff) ? (w_eff - WIDTH_W'(1)) : x_b;
        y_c  = (y_b >= h_eff) ? (h_eff - HEIGHT_W'(1)) : y_b;

        cmd.x_lo     = ADDR_W'(x_a);
        cmd.x_hi     = ADDR_W'(x_c);
        cmd.page_lo  = y_a[PAGE_W+2:3];
        cmd.page_hi  = y_c[PAGE_W+2:3];
        cmd.y_lo     = y_a[2:0];
        cmd.y_hi     = y_c[2:0];
        cmd.width    = w_eff;
        cmd.color    = color;
        cmd.write_en = 1'b1;
        if (op == OP_FILL)
        begin
            cmd.x_lo    = '0;
            cmd.x_hi    = ADDR_W'(STORE_BYTES - 1);
            cmd.page_lo = '0;
            cmd.page_hi = '0;
            cmd.y_lo    = 3'd0;
            cmd.y_hi    = 3'd7;
            cmd.width   = '0;
        end
        else if (op == OP_READ)
        begin
            cmd.x_lo     = read_addr;
            cmd.x_hi     = read_addr;
            cmd.page_lo  = '0;
            cmd.page_hi  = '0;
            cmd.width    = '0;
            cmd.write_en = 1'b0;
        end
    end

    assign start_walk = accept && ((op == OP_FILL) || (op == OP_READ) || (is_draw && !drop));

    mpfb_walk u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_walk),
        .cmd   (cmd),
        .stat  (stat)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = start_walk ? S_BUSY : S_HOLD;
                end
            end
            S_BUSY:
            begin
                if (stat.done)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            m_tvalid_reg      <= 1'b0;
            screen_width_reg  <= WIDTH_W'(128);
            screen_height_reg <= HEIGHT_W'(64);
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_HOLD) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                    CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[HEIGHT_W-1:0];
                    default:           screen_width_reg  <= screen_width_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_data_reg <= '0;
            res_drop_reg <= drop;
            is_read_reg  <= (op == OP_READ);
        end
        else if ((state_reg == S_BUSY) && stat.done && is_read_reg)
        begin
            res_data_reg <= stat.rdata;
        end
        if ((state_reg == S_HOLD) && out_free)
        begin
            m_tdata_reg <= res_data_reg;
            m_tuser_reg <= res_drop_reg;
        end
    end

    assign cfg_ready  = 1'b1;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    a_ready_walk_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !stat.busy)
        else $error("command taken while walker busy");

    a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (state_reg == S_BUSY))
        else $error("walker finished outside busy state");

    a_hold_walk_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD) |-> !stat.busy)
        else $error("result held while walker still running");

    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_BUSY) || (state_reg == S_HOLD))
        else $error("accepted command did not leave idle");

endmodule

`default_nettype wire

// ===== tb/mono_page_framebuffer_draw_test.sv =====
// self-checking regression of the page-packed monochrome frame buffer drawing engine
module mono_page_framebuffer_draw_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mpfb_pkg::*;

    typedef struct packed {
        op_t               op;
        logic [COL_W-1:0]  x_start;
        logic [ROW_W-1:0]  y_start;
        logic [COL_W-1:0]  x_end;
        logic [ROW_W-1:0]  y_end;
        logic              color;
        logic [ADDR_W-1:0] read_addr;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              dropped;
    } reply_t;

    typedef struct packed {
        cmd_t   cmd;
        logic   typed;
        reply_t reply;
    } dir_row_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        logic [WIDTH_W-1:0] height;
        int                 items;
    } geometry_t;

    localparam int DIR_ROWS   = 25;
    localparam int PHASES     = 8;
    localparam int LONG_HOLD  = 400;
    localparam int SETTLE     = 16;
    localparam int MAX_REPORT = 100;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata = '0;
    logic [OP_W-1:0]        s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [DATA_W-1:0]      m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [WIDTH_W-1:0]     cfg_data = '0;

    logic [DATA_W-1:0]      frame_model [STORE_BYTES];
    logic [WIDTH_W-1:0]     width_model = 8'd128;
    logic [HEIGHT_W-1:0]    height_model = 7'd64;
    reply_t                 pending_replies [$];

    int mismatches = 0;
    int items_sent = 0;
    int replies_checked = 0;
    int drops_seen = 0;
    int geometries_run = 0;
    int hold_requests = 0;
    int holds_done = 0;
    int hold_left = 0;
    int rx_mode = 0;
    int rx_span = 0;

    dir_row_t directed_rows [DIR_ROWS] = '{
        '{'{OP_FILL,  8'd0,   7'd0,   8'd0,   7'd0,   1'b1, 10'd0},    1'b1, '{8'h00, 1'b0}},
        '{'{OP_READ,  8'd0,   7'd0,   8'd0,   7'd0,   1'b0, 10'd0},    1'b1, '{8'hFF, 1'b0}},
        '{'{OP_READ,  8'd0,   7'd0,   8'd0,   7'd0,   1'b0, 10'd1023}, 1'b1, '{8'hFF, 1'b0}},
        '{'{OP_PIXEL, 8'd0,   7'd0,   8'd0,   7'd0,   1'b0, 10'd0},    1'b1, '{8'h00, 1'b0}},
        '{'{OP_READ,  8'd0,   7'd0,   8'd0,   7'd0,   1'b0, 10'd0},    1'b1, '{8'hFE, 1'b0}},
        '{'{OP_PIXEL, 8'd127, 7'd63,  8'd0,   7'd0,   1'b0, 10'd0},    1'b1, '{8'h00, 1'b0}},
        '{'{OP_READ,  8'd0,   7'd0,   8'd0,   7'd0,   1'b0, 10'd1023}, 1'b1, '{8'h7F, 1'b0}},
        '{'{OP_PIXEL, 8'd128, 7'd0,   8'd0,   7'd0,   1'b1, 10'd0},    1'b1, '{8'h00, 1'b1}},
        '{'{OP_PIXEL, 8'd0,   7'd64,  8'd0,   7'd0,   1'b1, 10'd0},    1'b1, '{8'h00, 1'b1}},
        '{'{OP_PIXEL, 8'd255, 7'd127, 8'd0,   7'd0,   1'b1, 10'd0},    1'b1, '{8'h00, 1'b1}},
        '{'{OP_FILL,  8'd0,   7'd0,   8'd0,   7'd0,   1'b0, 10'd0},    1'b1, '{8'h00, 1'b0}},
        '{'{OP_HLINE, 8'd200, 7'd3,   8'd5,   7'd0,   1'b1, 10'd0},    1'b0, '{8'h00, 1'b0}},
        '{'{OP_READ,  8'd0,   7'd0,   8'd0,   7'd0,   1'b0, 10'd5},    1'b1, '{8'h08, 1'b0}},
        '{'{OP_VLINE, 8'd10,  7'd60,  8'd0,   7'd2,   1'b1, 10'd0},    1'b0, '{8'h00, 1'b0}},
        '{'{OP_READ,  8'd0,   7'd0,   8'd0,   7'd0,   1'b0, 10'd10},   1'b0, '{8'h00, 1'b0}},
        '{'{OP_BOX,   8'd255, 7'd0,   8'd0,   7'd127, 1'b1, 10'd0},    1'b0, '{8'h00, 1'b0}},
        '{'{OP_BOX,   8'd20,  7'd120, 8'd40,  7'd127, 1'b1, 10'd0},    1'b1, '{8'h00, 1'b1}},
        '{'{OP_BOX,   8'd0,   7'd0,   8'd255, 7'd127, 1'b0, 10'd0},    1'b0, '{8'h00, 1'b0}},
        '{'{OP_BOX,   8'd3,   7'd5,   8'd3,   7'd5,   1'b1, 10'd0},    1'b0, '{8'h00, 1'b0}},
        '{'{OP_BOX,   8'd7,   7'd5,   8'd0,   7'd2,   1'b1, 10'd0},    1'b0, '{8'h00, 1'b0}},
        '{'{OP_READ,  8'd0,   7'd0,   8'd0,   7'd0,   1'b0, 10'd2},    1'b0, '{8'h00, 1'b0}},
        '{'{OP_RSV6,  8'd255, 7'd127, 8'd255, 7'd127, 1'b1, 10'd1023}, 1'b1, '{8'h00, 1'b0}},
        '{'{OP_RSV7,  8'd255, 7'd127, 8'd255, 7'd127, 1'b1, 10'd1023}, 1'b1, '{8'h00, 1'b0}},
        '{'{OP_VLINE, 8'd127, 7'd0,   8'd255, 7'd127, 1'b1, 10'd0},    1'b0, '{8'h00, 1'b0}},
        '{'{OP_READ,  8'd255, 7'd127, 8'd255, 7'd127, 1'b1, 10'd1023}, 1'b0, '{8'h00, 1'b0}}
    };

    geometry_t phases [PHASES] = '{
        '{8'd128, 8'd64,  300},
        '{8'd1,   8'd1,   100},
        '{8'd255, 8'hFF,  150},
        '{8'd0,   8'd64,  60},
        '{8'd40,  8'd0,   60},
        '{8'd37,  8'd23,  200},
        '{8'd128, 8'd8,   150},
        '{8'd8,   8'd64,  150}
    };

    mono_page_framebuffer_draw dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic reply_t predict_draw(cmd_t c);
        int unsigned w, h, xs, ys, xe, ye, t, p, x, ofs;
        logic [DATA_W-1:0] m;
        reply_t r;
        r = '0;
        w = (width_model > MAX_WIDTH) ? MAX_WIDTH : width_model;
        h = (height_model > MAX_HEIGHT) ? MAX_HEIGHT : height_model;
        xs = c.x_start;
        ys = c.y_start;
        xe = c.x_end;
        ye = c.y_end;
        case (c.op)
            OP_FILL:
                foreach (frame_model[i])
                    frame_model[i] = c.color ? FULL_BYTE : '0;
            OP_PIXEL:
            begin
                xe = xs;
                ye = ys;
            end
            OP_HLINE: ye = ys;
            OP_VLINE: xe = xs;
            OP_READ:  r.read_data = (c.read_addr < STORE_BYTES) ? frame_model[c.read_addr] : '0;
            default: ;
        endcase
        if (c.op inside {OP_PIXEL, OP_HLINE, OP_VLINE, OP_BOX})
        begin
            if (xe < xs)
            begin
                t = xs;
                xs = xe;
                xe = t;
            end
            if (ye < ys)
            begin
                t = ys;
                ys = ye;
                ye = t;
            end
            if (xs >= w || ys >= h)
                r.dropped = 1'b1;
            else
            begin
                if (xe >= w)
                    xe = w - 1;
                if (ye >= h)
                    ye = h - 1;
                for (p = ys >> 3; p <= (ye >> 3); p++)
                begin
                    m = FULL_BYTE;
                    if (p == (ys >> 3))
                        m = m & (FULL_BYTE << (ys & 7));
                    if (p == (ye >> 3))
                        m = m & (FULL_BYTE >> (7 - (ye & 7)));
                    for (x = xs; x <= xe; x++)
                    begin
                        ofs = p * w + x;
                        if (ofs < STORE_BYTES)
                        begin
                            if (m == FULL_BYTE)
                                frame_model[ofs] = c.color ? FULL_BYTE : '0;
                            else if (c.color)
                                frame_model[ofs] = frame_model[ofs] | m;
                            else
                                frame_model[ofs] = frame_model[ofs] & ~m;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    // mostly on-screen shapes of small extent, some noise and full-range ends
    function automatic cmd_t random_cmd();
        int unsigned w, h, pick, span;
        cmd_t c;
        w = (width_model > MAX_WIDTH) ? MAX_WIDTH : width_model;
        h = (height_model > MAX_HEIGHT) ? MAX_HEIGHT : height_model;
        c.x_start = COL_W'($urandom());
        c.y_start = ROW_W'($urandom());
        c.x_end = COL_W'($urandom());
        c.y_end = ROW_W'($urandom());
        c.color = 1'($urandom());
        c.read_addr = ADDR_W'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 2)
            c.op = OP_FILL;
        else if (pick < 22)
            c.op = OP_PIXEL;
        else if (pick < 36)
            c.op = OP_HLINE;
        else if (pick < 50)
            c.op = OP_VLINE;
        else if (pick < 70)
            c.op = OP_BOX;
        else if (pick < 96)
            c.op = OP_READ;
        else
            c.op = pick[0] ? OP_RSV7 : OP_RSV6;
        if (c.op inside {OP_PIXEL, OP_HLINE, OP_VLINE, OP_BOX} && w != 0 && h != 0
            && $urandom_range(0, 9) != 0)
        begin
            c.x_start = COL_W'($urandom_range(0, w - 1));
            c.y_start = ROW_W'($urandom_range(0, h - 1));
            if ($urandom_range(0, 19) != 0)
            begin
                span = $urandom_range(0, 8);
                c.x_end = $urandom_range(0, 1) ? c.x_start + COL_W'(span)
                                               : c.x_start - COL_W'(span);
                span = $urandom_range(0, 15);
                c.y_end = $urandom_range(0, 1) ? c.y_start + ROW_W'(span)
                                               : c.y_start - ROW_W'(span);
            end
        end
        return c;
    endfunction

    task automatic flag_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORT)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task automatic push_cmd(cmd_t c, logic typed, reply_t fixed);
        reply_t r;
        s_tvalid <= 1'b1;
        s_tdata <= {c.read_addr, c.color, c.y_end, c.x_end, c.y_start, c.x_start};
        s_tuser <= c.op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = predict_draw(c);
        pending_replies.push_back(typed ? fixed : r);
        items_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WIDTH_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_SCREEN_WIDTH)
            width_model = value;
        else
            height_model = value[HEIGHT_W-1:0];
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_stream(int count, logic with_pressure);
        int burst_left, gap;
        burst_left = $urandom_range(1, 24);
        for (int i = 0; i < count; i++)
        begin
            if (with_pressure && i == count / 3)
                hold_requests++;
            push_cmd(random_cmd(), 1'b0, '0);
            if (with_pressure && i == (2 * count) / 3)
            begin
                // let every outstanding word come back before going on
                s_tvalid <= 1'b0;
                while (pending_replies.size() != 0)
                    @(posedge clk);
            end
            else
            begin
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap = $urandom_range(0, 10);
                    if (gap != 0)
                    begin
                        s_tvalid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // output side: random stall patterns plus requested long hold-offs
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done++;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (rx_span == 0)
                begin
                    rx_mode = $urandom_range(0, 3);
                    rx_span = $urandom_range(16, 80);
                end
                rx_span--;
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom());
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial
    begin
        reply_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_replies.size() == 0)
                    flag_mismatch($sformatf("unexpected word read_data %02h dropped %0b",
                                            m_tdata, m_tuser[0]));
                else
                begin
                    want = pending_replies.pop_front();
                    replies_checked++;
                    if (m_tuser[0] === 1'b1)
                        drops_seen++;
                    if (m_tdata !== want.read_data)
                        flag_mismatch($sformatf("word %0d read_data %02h, expected %02h",
                                                replies_checked, m_tdata, want.read_data));
                    if (m_tuser[0] !== want.dropped)
                        flag_mismatch($sformatf("word %0d dropped %0b, expected %0b",
                                                replies_checked, m_tuser[0], want.dropped));
                end
            end
        end
    end

    initial
    begin
        #30_000_000;
        $display("mono_page_framebuffer_draw regression: fail");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
            push_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].reply);
        s_tvalid <= 1'b0;
        geometries_run = 1;
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            write_reg(CFG_SCREEN_WIDTH, phases[p].width);
            write_reg(CFG_SCREEN_HEIGHT, phases[p].height);
            geometries_run++;
            send_stream(phases[p].items, p == 0);
        end
        wait_drained();
        $display("ran %0d drawing and read commands under %0d screen geometries",
                 items_sent, geometries_run);
        $display("compared %0d result words, %0d of them dropped commands, %0d long stalls",
                 replies_checked, drops_seen, holds_done);
        if (mismatches == 0)
            $display("mono_page_framebuffer_draw regression: pass");
        else
            $display("mono_page_framebuffer_draw regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mpfb_pkg.sv
src/mpfb_ram.sv
src/mpfb_walk.sv
src/mono_page_framebuffer_draw.sv
tb/mono_page_framebuffer_draw_test.sv
